@@ sv/mcpid_pkg.sv @@
// Shared types, constants and register codes for the multi-channel PID filter.
`default_nettype none

package mcpid_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int DATA_W = 32;
    localparam int CH_W   = 2;
    localparam int AXES   = 3;
    localparam int REG_W  = 2;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 32'd65536000;
    localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 32'd0;
    localparam logic [DATA_W-1:0] DERIV_GAIN_RST = 32'd0;
    localparam logic [DATA_W-1:0] DERIV_POLE_RST = 32'd0;

    typedef enum logic [REG_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2,
        REG_DERIV_POLE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] ki;
        logic [DATA_W-1:0] kd;
        logic [DATA_W-1:0] pole;
    } t_gains;

endpackage

`default_nettype wire

@@ sv/mcpid_axis.sv @@
// One axis of the PID datapath: products, rounding, saturation and the new state.
`default_nettype none

module mcpid_axis #(
    parameter int FRAC_BITS = mcpid_pkg::FRAC_BITS_DEF
) (
    input  var mcpid_pkg::t_gains i_gains,
    input  logic signed [31:0]    i_err,
    input  logic signed [31:0]    i_prev_err,
    input  logic signed [31:0]    i_integ_old,
    input  logic signed [31:0]    i_deriv_old,
    output logic signed [31:0]    o_integ_new,
    output logic signed [31:0]    o_deriv_new,
    output logic signed [31:0]    o_drive
);

    localparam int EXT_W = 66;
    localparam int RND_W = EXT_W - FRAC_BITS;
    localparam int SUM_W = RND_W + 2;
    localparam logic signed [EXT_W-1:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic signed [32:0]      err_sum;
    logic signed [32:0]      err_diff;
    logic signed [63:0]      p_prod;
    logic signed [64:0]      i_prod;
    logic signed [64:0]      d_prod;
    logic signed [63:0]      f_prod;
    logic signed [EXT_W-1:0] p_ext;
    logic signed [EXT_W-1:0] i_ext;
    logic signed [EXT_W-1:0] d_ext;
    logic signed [EXT_W-1:0] f_ext;
    logic signed [RND_W-1:0] p_rnd;
    logic signed [RND_W-1:0] i_rnd;
    logic signed [RND_W-1:0] d_rnd;
    logic signed [RND_W-1:0] f_rnd;
    logic signed [SUM_W-1:0] i_pre;
    logic signed [SUM_W-1:0] d_pre;
    logic signed [SUM_W-1:0] y_pre;

    function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
        logic hi_zeros;
        logic hi_ones;
        hi_zeros = (v[SUM_W-1:31] == '0);
        hi_ones  = &v[SUM_W-1:31];
        if (hi_zeros || hi_ones) begin
            return v[31:0];
        end else if (v[SUM_W-1]) begin
            return mcpid_pkg::S32_MIN;
        end else begin
            return mcpid_pkg::S32_MAX;
        end
    endfunction

    always_comb begin
        err_sum  = 33'(i_err) + 33'(i_prev_err);
        err_diff = 33'(i_err) - 33'(i_prev_err);

        p_prod = $signed(i_gains.kp) * i_err;
        i_prod = $signed(i_gains.ki) * err_sum;
        d_prod = $signed(i_gains.kd) * err_diff;
        f_prod = $signed(i_gains.pole) * i_deriv_old;

        // Round to nearest with ties towards plus infinity.
        p_ext = EXT_W'(p_prod) + RND_HALF;
        i_ext = EXT_W'(i_prod) + RND_HALF;
        d_ext = EXT_W'(d_prod) + RND_HALF;
        f_ext = EXT_W'(f_prod) + RND_HALF;
        p_rnd = p_ext[EXT_W-1:FRAC_BITS];
        i_rnd = i_ext[EXT_W-1:FRAC_BITS];
        d_rnd = d_ext[EXT_W-1:FRAC_BITS];
        f_rnd = f_ext[EXT_W-1:FRAC_BITS];

        i_pre       = SUM_W'(i_rnd) + SUM_W'(i_integ_old);
        o_integ_new = sat32(i_pre);
        d_pre       = SUM_W'(d_rnd) - SUM_W'(f_rnd);
        o_deriv_new = sat32(d_pre);

        y_pre   = SUM_W'(p_rnd) + SUM_W'(o_integ_new) + SUM_W'(o_deriv_new);
        o_drive = sat32(y_pre);
    end

endmodule

`default_nettype wire

@@ sv/multi_channel_pid_filtered_derivative_top.sv @@
// Multi-channel PID with trapezoidal integral and filtered derivative, top level.
// Path: a beat accepted into the input register is worked combinationally from it, and its
// result is registered in the output register, from which it is offered downstream.
// Throughput: one beat per cycle, also on the same channel; a stalled output holds both
// registers, and the input takes a beat while its register is empty or moving on.
// Reset clears the handshake state and all integral and derivative state, and loads the reset gains, at once.
`default_nettype none

module multi_channel_pid_filtered_derivative_top #(
    parameter int NUM_CHANNELS = mcpid_pkg::NUM_CHANNELS_DEF,
    parameter int FRAC_BITS    = mcpid_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration writes.
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    // Input stream.
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // err_x, err_y, err_z, prev_err_x, prev_err_y, prev_err_z, 32 bits each
    input  logic [191:0]  i_s_tdata,
    // channel
    input  logic [1:0]    i_s_tuser,
    // Output stream.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // drive_x, drive_y, drive_z, 32 bits each
    output logic [95:0]   o_m_tdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    mcpid_pkg::t_gains r_gains;

    logic                  r_in_valid;
    logic [1:0]            r_channel;
    logic [2:0][31:0]      r_err;
    logic [2:0][31:0]      r_prev;
    logic                  r_out_valid;
    logic [95:0]           r_out_data;

    logic [NUM_CHANNELS-1:0][2:0][31:0] r_integ;
    logic [NUM_CHANNELS-1:0][2:0][31:0] r_deriv;

    logic                  in_accept;
    logic                  advance;
    logic                  ch_ok;
    logic [IDX_W-1:0]      row;
    logic [2:0][31:0]      integ_new;
    logic [2:0][31:0]      deriv_new;
    logic [2:0][31:0]      drive;
    logic [95:0]           n_out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp   <= mcpid_pkg::PROP_GAIN_RST;
            r_gains.ki   <= mcpid_pkg::INTEG_GAIN_RST;
            r_gains.kd   <= mcpid_pkg::DERIV_GAIN_RST;
            r_gains.pole <= mcpid_pkg::DERIV_POLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mcpid_pkg::t_reg_idx'(i_cfg_index))
                mcpid_pkg::REG_PROP_GAIN:  r_gains.kp   <= i_cfg_data;
                mcpid_pkg::REG_INTEG_GAIN: r_gains.ki   <= i_cfg_data;
                mcpid_pkg::REG_DERIV_GAIN: r_gains.kd   <= i_cfg_data;
                mcpid_pkg::REG_DERIV_POLE: r_gains.pole <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_channel <= i_s_tuser;
            r_err     <= i_s_tdata[95:0];
            r_prev    <= i_s_tdata[191:96];
        end
    end

    assign ch_ok = (32'(r_channel) < NUM_CHANNELS);
    assign row   = IDX_W'(r_channel);

    for (genvar a = 0; a < mcpid_pkg::AXES; a++) begin : g_axis
        mcpid_axis #(
            .FRAC_BITS(FRAC_BITS)
        ) u_axis (
            .i_gains    (r_gains),
            .i_err      ($signed(r_err[a])),
            .i_prev_err ($signed(r_prev[a])),
            .i_integ_old($signed(r_integ[row][a])),
            .i_deriv_old($signed(r_deriv[row][a])),
            .o_integ_new(integ_new[a]),
            .o_deriv_new(deriv_new[a]),
            .o_drive    (drive[a])
        );
    end

    assign n_out_data = ch_ok ? drive : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_deriv <= '0;
        end else if (advance && ch_ok) begin
            r_integ[row] <= integ_new;
            r_deriv[row] <= deriv_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("Result register not loaded after an item advanced.");

    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !ch_ok) |=> (r_out_data == '0))
        else $error("Out-of-range channel gave a non-zero result.");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && ch_ok) |=> ($stable(r_integ) && $stable(r_deriv)))
        else $error("Controller state changed without an item advancing.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_in_valid) |-> advance)
        else $error("Input register overwritten while it still held an item.");

endmodule

`default_nettype wire
